>>> src/erlang_function_head_finder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the function head finder
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ERLANG_FUNCTION_HEAD_FINDER_TOP_DEFINES_SVH
`define ERLANG_FUNCTION_HEAD_FINDER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EFHF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EFHF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/efhf_pkg.sv
// ----------------------------------------------------------------------------
// Function head finder package
// Sizes, scan modes, shared types, character class helpers and end-of-line cleanup.
// ----------------------------------------------------------------------------
package efhf_pkg;

	localparam int NAME_SLOTS  = 64;
	localparam int STACK_DEPTH = 32;
	localparam int CHAR_BITS   = 16;
	localparam int NAME_AW     = $clog2(NAME_SLOTS);
	localparam int LEN_W       = NAME_AW + 1;

	// Scan modes.
	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_NAME  = 3'd1;
	localparam logic [2:0] M_QNAME = 3'd2;
	localparam logic [2:0] M_CAND  = 3'd3;
	localparam logic [2:0] M_ARGS1 = 3'd4;
	localparam logic [2:0] M_ARGS  = 3'd5;
	localparam logic [2:0] M_FIN   = 3'd6;

	// Bracket codes.
	localparam logic [1:0] BR_PAREN = 2'd0;
	localparam logic [1:0] BR_SQUARE = 2'd1;
	localparam logic [1:0] BR_CURLY = 2'd2;
	localparam logic [1:0] BR_NUL = 2'd3;

	// Quote kinds.
	localparam logic [1:0] Q_NONE   = 2'd0;
	localparam logic [1:0] Q_DOUBLE = 2'd1;
	localparam logic [1:0] Q_SINGLE = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic       skip;
		logic [1:0] qk;
		logic       pwd;
		logic [2:0] kp;
	} core_t;

	// Control for the bracket cell row.
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctrl_t;

	function automatic logic is_head(input logic [CHAR_BITS-1:0] c);
		return (c >= CHAR_BITS'("a") && c <= CHAR_BITS'("z")) ||
			c == CHAR_BITS'("_") || c == CHAR_BITS'("@");
	endfunction

	function automatic logic is_alnum(input logic [CHAR_BITS-1:0] c);
		return is_head(c) || (c >= CHAR_BITS'("A") && c <= CHAR_BITS'("Z")) ||
			(c >= CHAR_BITS'("0") && c <= CHAR_BITS'("9"));
	endfunction

	function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
		return c == CHAR_BITS'(" ") || c == CHAR_BITS'(9) || c == CHAR_BITS'(13) ||
			c == CHAR_BITS'(10) || c == '0;
	endfunction

	// End-of-line cleanup of the scan state.
	function automatic core_t close_line(input core_t s);
		core_t r;
		r = s;
		r.skip = 1'b0;
		r.qk = Q_NONE;
		r.pwd = 1'b0;
		if (r.kp != 3'd0) begin
			r.kp = 3'd0;
			r.mode = M_IDLE;
		end
		if (r.mode == M_NAME) begin
			r.mode = M_CAND;
		end else if (r.mode == M_QNAME) begin
			r.mode = M_IDLE;
		end
		return r;
	endfunction

endpackage

>>> src/erlang_function_head_finder_top.sv
// Throughput: one input request per cycle while text is being scanned.
// A confirming character stalls input while the name run is read out.
// A mismatched closer stalls input while the bracket cells are searched for its opener.
// Each result passes the name read register and the output register; then one per cycle while m_tready is high.
// Reset (arst_n low, asynchronous) returns to idle scan with an empty stack.
// ----------------------------------------------------------------------------
// Erlang function head finder
// Scans text for column-one atoms followed by an argument list and -> or when.
// ----------------------------------------------------------------------------
`include "erlang_function_head_finder_top_defines.svh"

module erlang_function_head_finder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // ch [15:0], line_number [39:16]
	input  logic [0:0]  s_tuser,  // line_start [0]
	input  logic        s_tlast,  // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // name_char [15:0], func_line [39:16], arity [55:40]
	output logic [0:0]  m_tuser,  // char_valid [0]
	output logic        m_tlast   // last
);
	import efhf_pkg::*;

	localparam logic [1:0] PH_RUN = 2'd0;
	localparam logic [1:0] PH_SEARCH = 2'd1;
	localparam logic [1:0] PH_EMIT = 2'd2;

	logic [1:0]           phase_q, phase_d;
	core_t                core_q, core_d;
	logic [LEN_W-1:0]     nlen_q, nlen_d;
	logic                 nq_q, nq_d;
	logic [23:0]          hline_q, hline_d;
	logic [15:0]          argc_q, argc_d;
	logic [15:0]          depth_q, depth_d;
	logic [1:0]           scode_q, scode_d;
	stk_ctrl_t            sctl;
	logic [1:0]           push_code;
	logic [1:0]           cell_code [STACK_DEPTH];
	logic                 st_en;
	logic [NAME_AW-1:0]   st_addr;
	logic [CHAR_BITS-1:0] name_mem [NAME_SLOTS];
	logic                 go_emit;

	// Input fields.
	logic [CHAR_BITS-1:0] ch;
	logic                 ls, le;
	logic [23:0]          ln;
	assign ch = s_tdata[15:0];
	assign ln = s_tdata[39:16];
	assign ls = s_tuser[0];
	assign le = s_tlast;

	assign s_tready = (phase_q == PH_RUN);

	// Bracket stack as a row of cells; cell 0 is the top.
	for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
		logic [1:0] up, dn;
		if (j == 0) begin : g_top
			assign up = push_code;
		end else begin : g_mid
			assign up = cell_code[j-1];
		end
		if (j == STACK_DEPTH - 1) begin : g_bot
			assign dn = cell_code[j];
		end else begin : g_low
			assign dn = cell_code[j+1];
		end
		efhf_cell u_cell (
			.clk        (clk),
			.ctrl       (sctl),
			.upper_code (up),
			.lower_code (dn),
			.code       (cell_code[j])
		);
	end

	// Emission control signals.
	logic [LEN_W-1:0] ptr_q, max_ptr;
	logic             rv_q, rd_cv_q, rd_last_q, issue, take;
	logic [CHAR_BITS-1:0] rd_data_q;
	assign max_ptr = (nlen_q == '0) ? LEN_W'(1) : nlen_q;
	assign take = rv_q && (!m_tvalid || m_tready);
	assign issue = (phase_q == PH_EMIT) && (ptr_q < max_ptr) && (!rv_q || take);

	// Next-state logic for one character, the bracket search and emission.
	always_comb begin
		core_t      cs;
		logic       run_cand, run_a1, run_args, digit;
		logic [1:0] cl_code;
		logic [15:0] cm1;
		logic [LEN_W-1:0] cap;
		cs = core_q;
		core_d = core_q;
		nlen_d = nlen_q;
		nq_d = nq_q;
		hline_d = hline_q;
		argc_d = argc_q;
		depth_d = depth_q;
		scode_d = scode_q;
		phase_d = phase_q;
		sctl = '0;
		push_code = BR_PAREN;
		st_en = 1'b0;
		st_addr = '0;
		go_emit = 1'b0;
		run_cand = 1'b0;
		run_a1 = 1'b0;
		run_args = 1'b0;
		digit = 1'b0;
		cl_code = BR_PAREN;
		cm1 = depth_q - 16'd1;
		cap = '0;
		if (phase_q == PH_RUN && s_tvalid) begin
			if (ls) begin
				cs = close_line(cs);
			end
			if (!cs.skip) begin
				case (cs.mode)
					M_IDLE: begin
						if (ls && (is_head(ch) || ch == CHAR_BITS'("'"))) begin
							nlen_d = '0;
							nq_d = (ch == CHAR_BITS'("'"));
							hline_d = ln;
							if (nq_d) begin
								cs.mode = M_QNAME;
							end else begin
								cs.mode = M_NAME;
								st_en = 1'b1;
							end
						end
					end
					M_NAME: begin
						if (is_alnum(ch)) begin
							st_en = 1'b1;
						end else begin
							cs.mode = M_CAND;
							run_cand = 1'b1;
						end
					end
					M_QNAME: begin
						if (ch == CHAR_BITS'("'")) begin
							cs.mode = M_CAND;
						end else begin
							st_en = 1'b1;
						end
					end
					M_CAND: run_cand = 1'b1;
					M_ARGS1: run_a1 = 1'b1;
					M_ARGS: run_args = 1'b1;
					M_FIN: begin
						if (cs.kp == 3'd0) begin
							if (is_space(ch)) begin
							end else if (ch == CHAR_BITS'("-")) begin
								cs.kp = 3'd1;
							end else if (ch == CHAR_BITS'("w")) begin
								cs.kp = 3'd2;
							end else if (ch == CHAR_BITS'("%")) begin
								cs.skip = 1'b1;
							end else begin
								cs.mode = M_IDLE;
							end
						end else if ((cs.kp == 3'd1 && ch == CHAR_BITS'(">")) ||
								(cs.kp == 3'd4 && ch == CHAR_BITS'("n"))) begin
							cs.kp = 3'd0;
							cs.mode = M_IDLE;
							cs.skip = 1'b1;
							go_emit = 1'b1;
						end else if ((cs.kp == 3'd2 && ch == CHAR_BITS'("h")) ||
								(cs.kp == 3'd3 && ch == CHAR_BITS'("e"))) begin
							cs.kp = cs.kp + 3'd1;
						end else begin
							cs.kp = 3'd0;
							cs.mode = M_IDLE;
						end
					end
					default: cs.mode = M_IDLE;
				endcase
				// Name character store with its length cap.
				if (st_en) begin
					cap = nq_d ? LEN_W'(NAME_SLOTS - 2) : LEN_W'(NAME_SLOTS - 1);
					if (nlen_d < cap) begin
						st_addr = nlen_d[NAME_AW-1:0];
						nlen_d = nlen_d + LEN_W'(1);
					end else begin
						st_en = 1'b0;
					end
				end
				// Waiting for the opening parenthesis.
				if (run_cand) begin
					if (is_space(ch)) begin
					end else if (ch == CHAR_BITS'("%")) begin
						cs.skip = 1'b1;
					end else if (ch == CHAR_BITS'("(")) begin
						cs.mode = M_ARGS1;
						argc_d = '0;
						depth_d = 16'd1;
						sctl.push = 1'b1;
						push_code = BR_PAREN;
					end else begin
						cs.mode = M_IDLE;
					end
				end
				// First character inside the argument list.
				if (run_a1) begin
					if (is_space(ch)) begin
					end else if (ch == CHAR_BITS'(")")) begin
						cs.mode = M_FIN;
					end else if (ch == CHAR_BITS'("%")) begin
						cs.skip = 1'b1;
					end else begin
						cs.mode = M_ARGS;
						if (argc_d != 16'hFFFF) begin
							argc_d = argc_d + 16'd1;
						end
						run_args = 1'b1;
					end
				end
				// Argument scan.
				if (run_args) begin
					digit = (ch >= CHAR_BITS'("0") && ch <= CHAR_BITS'("9"));
					if (cs.qk != Q_NONE) begin
						if ((cs.qk == Q_DOUBLE && ch == CHAR_BITS'("\"")) ||
								(cs.qk == Q_SINGLE && ch == CHAR_BITS'("'"))) begin
							cs.qk = Q_NONE;
						end
					end else if (ch == CHAR_BITS'("(") || ch == CHAR_BITS'("[") ||
							ch == CHAR_BITS'("{") || ch == '0) begin
						if (depth_d != 16'hFFFF) begin
							if (depth_d < 16'(STACK_DEPTH)) begin
								sctl.push = 1'b1;
								push_code = (ch == CHAR_BITS'("(")) ? BR_PAREN :
									(ch == CHAR_BITS'("[")) ? BR_SQUARE :
									(ch == CHAR_BITS'("{")) ? BR_CURLY : BR_NUL;
							end
							depth_d = depth_d + 16'd1;
						end
					end else if (ch == CHAR_BITS'(")") || ch == CHAR_BITS'("]") ||
							ch == CHAR_BITS'("}")) begin
						cl_code = (ch == CHAR_BITS'(")")) ? BR_PAREN :
							(ch == CHAR_BITS'("]")) ? BR_SQUARE : BR_CURLY;
						depth_d = cm1;
						if (cm1 < 16'(STACK_DEPTH)) begin
							sctl.pop = 1'b1;
						end
						if (cm1 == 16'd0) begin
							cs.mode = M_FIN;
						end else if (cm1 < 16'(STACK_DEPTH) && cell_code[0] != cl_code) begin
							phase_d = PH_SEARCH;
							scode_d = cl_code;
						end
					end else if (ch == CHAR_BITS'(",")) begin
						if (depth_d == 16'd1 && argc_d != 16'hFFFF) begin
							argc_d = argc_d + 16'd1;
						end
					end else if (ch == CHAR_BITS'(";")) begin
						cs.mode = M_IDLE;
					end else if (ch == CHAR_BITS'(".")) begin
						if (!cs.pwd) begin
							cs.mode = M_IDLE;
						end
					end else if (ch == CHAR_BITS'("\"")) begin
						cs.qk = Q_DOUBLE;
					end else if (ch == CHAR_BITS'("'")) begin
						cs.qk = Q_SINGLE;
					end else if (ch == CHAR_BITS'("%")) begin
						cs.skip = 1'b1;
					end
				end
			end
			cs.pwd = digit;
			if (le) begin
				cs = close_line(cs);
			end
			core_d = cs;
			if (go_emit) begin
				phase_d = PH_EMIT;
			end
		end else if (phase_q == PH_SEARCH) begin
			// Pop one cell per cycle down to the topmost matching opener.
			depth_d = cm1;
			if (cm1 == 16'd0) begin
				core_d.mode = M_FIN;
				phase_d = PH_RUN;
			end else begin
				sctl.pop = 1'b1;
				if (cell_code[0] == scode_q) begin
					phase_d = PH_RUN;
				end
			end
		end else if (phase_q == PH_EMIT) begin
			if (ptr_q == max_ptr && !rv_q) begin
				phase_d = PH_RUN;
			end
		end
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RUN;
			core_q <= '{mode: M_IDLE, skip: 1'b0, qk: Q_NONE, pwd: 1'b0, kp: 3'd0};
			nlen_q <= '0;
			nq_q <= 1'b0;
			hline_q <= '0;
			argc_q <= '0;
			depth_q <= '0;
			scode_q <= BR_PAREN;
		end else begin
			phase_q <= phase_d;
			core_q <= core_d;
			nlen_q <= nlen_d;
			nq_q <= nq_d;
			hline_q <= hline_d;
			argc_q <= argc_d;
			depth_q <= depth_d;
			scode_q <= scode_d;
		end
	end

	// Name store: written during the scan, read during emission.
	always_ff @(posedge clk) begin
		if (st_en && phase_q == PH_RUN && s_tvalid) begin
			name_mem[st_addr] <= ch;
		end
		if (issue) begin
			rd_data_q <= name_mem[ptr_q[NAME_AW-1:0]];
			rd_cv_q <= (nlen_q != '0);
			rd_last_q <= (nlen_q == '0) || (ptr_q + LEN_W'(1) == nlen_q);
		end
	end

	// Read pointer and read-data valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			rv_q <= 1'b0;
		end else begin
			if (phase_q == PH_RUN) begin
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + LEN_W'(1);
			end
			if (issue) begin
				rv_q <= 1'b1;
			end else if (take) begin
				rv_q <= 1'b0;
			end
		end
	end

	// Output register; line and arity are captured with each result so that
	// a waiting result stays intact once the scan resumes.
	logic [CHAR_BITS-1:0] och_q;
	logic                 ocv_q, olast_q;
	logic [23:0]          oline_q;
	logic [15:0]          oarity_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			och_q <= rd_cv_q ? rd_data_q : '0;
			ocv_q <= rd_cv_q;
			olast_q <= rd_last_q;
			oline_q <= hline_q;
			oarity_q <= argc_q;
		end
	end

	assign m_tdata = {8'd0, oarity_q, oline_q, och_q};
	assign m_tuser = ocv_q;
	assign m_tlast = olast_q;

	`EFHF_ASSERT_IMP(a_search_depth, phase_q == PH_SEARCH,
		depth_q != 16'd0 && depth_q < 16'(STACK_DEPTH), "bracket search out of stored range")
	`EFHF_ASSERT_IMP(a_empty_is_last, m_tvalid && !m_tuser[0], m_tlast,
		"empty name result is not last")
	`EFHF_ASSERT_IMP(a_ptr_bound, phase_q == PH_EMIT, ptr_q <= max_ptr,
		"name read pointer past length")
	`EFHF_ASSERT_NEXT(a_emit_entry, phase_q == PH_RUN && s_tvalid && go_emit,
		phase_q == PH_EMIT, "confirmed head did not start emission")

endmodule

>>> src/efhf_cell.sv
// ----------------------------------------------------------------------------
// Bracket stack cell
// Holds one bracket code; takes its upper neighbor on push, lower on pop.
// ----------------------------------------------------------------------------
module efhf_cell (
	input  logic                 clk,
	input  efhf_pkg::stk_ctrl_t  ctrl,
	input  logic [1:0]           upper_code,
	input  logic [1:0]           lower_code,
	output logic [1:0]           code
);
	import efhf_pkg::*;

	logic [1:0] code_q;

	// Shift toward the bottom on push, toward the top on pop.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			code_q <= upper_code;
		end else if (ctrl.pop) begin
			code_q <= lower_code;
		end
	end

	assign code = code_q;

endmodule
